>>> rtl/ssc_pkg.sv
`default_nettype none
package ssc_pkg;

  localparam int unsigned RangeW = 16;
  localparam int unsigned AngleW = 32;
  localparam int unsigned StartW = 16;
  localparam int unsigned StepW  = 14;
  localparam int unsigned CfgIdxW = 3;

  // sector edges in units of 1/8192 rad: 0.5 rad and 1.57 rad
  localparam logic signed [AngleW-1:0] HALF_RAD = 32'sd4096;
  localparam logic signed [AngleW-1:0] EDGE_RAD = 32'sd12861;

  localparam logic signed [AngleW-1:0] ANGLE_SAT_HI = 32'sh7fff_ffff;
  localparam logic signed [AngleW-1:0] ANGLE_SAT_LO = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DIST_FLOOR  = 3'd0,
    CFG_DIST_CEIL   = 3'd1,
    CFG_ANGLE_START = 3'd2,
    CFG_ANGLE_STEP  = 3'd3,
    CFG_SAFETY      = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [RangeW-1:0]        dist_floor;
    logic [RangeW-1:0]        dist_ceil;
    logic signed [StartW-1:0] angle_start;
    logic signed [StepW-1:0]  angle_step;
    logic [RangeW-1:0]        safety_distance;
  } cfg_t;

  typedef struct packed {
    logic [RangeW-1:0] range_sample;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [RangeW-1:0] front_clearance;
    logic [RangeW-1:0] left_clearance;
    logic [RangeW-1:0] right_clearance;
    logic              obstacle_flag;
  } out_item_t;

endpackage
`default_nettype wire

>>> rtl/ssc_cfg_regs.sv
`default_nettype none
module ssc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [ssc_pkg::RangeW-1:0]     cfg_wdata_i,
  output ssc_pkg::cfg_t                       cfg_o
);

  ssc_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ssc_pkg::CFG_DIST_FLOOR:  cfg_d.dist_floor = cfg_wdata_i;
        ssc_pkg::CFG_DIST_CEIL:   cfg_d.dist_ceil = cfg_wdata_i;
        ssc_pkg::CFG_ANGLE_START: cfg_d.angle_start = cfg_wdata_i[ssc_pkg::StartW-1:0];
        ssc_pkg::CFG_ANGLE_STEP:  cfg_d.angle_step = cfg_wdata_i[ssc_pkg::StepW-1:0];
        ssc_pkg::CFG_SAFETY:      cfg_d.safety_distance = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dist_floor      <= 16'd100;
      cfg_q.dist_ceil       <= 16'd12000;
      cfg_q.angle_start     <= -16'sd25736;
      cfg_q.angle_step      <= 14'sd143;
      cfg_q.safety_distance <= 16'd500;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> rtl/ssc_sector_track.sv
`default_nettype none
module ssc_sector_track (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssc_pkg::cfg_t     cfg_i,
  input  wire logic              proc_i,
  input  wire ssc_pkg::in_item_t item_i,
  output ssc_pkg::out_item_t     res_o
);

  localparam int unsigned RW = ssc_pkg::RangeW;
  localparam int unsigned AW = ssc_pkg::AngleW;

  logic [RW-1:0] front_d, front_q, left_d, left_q, right_d, right_q;
  logic signed [AW-1:0] angle_d, angle_q;
  logic start_d, start_q;

  logic [RW-1:0] front_c, left_c, right_c, r;
  logic signed [AW-1:0] a;
  logic signed [AW:0] sum;
  logic in_range, in_left, in_right, in_front;
  logic [RW+2:0] left_x5, right_x5, safety_x3;

  always_comb begin
    r = item_i.range_sample;
    // first sample of a scan starts from the distance ceiling and angle_start
    if (start_q) begin
      front_c = cfg_i.dist_ceil;
      left_c  = cfg_i.dist_ceil;
      right_c = cfg_i.dist_ceil;
      a = AW'(cfg_i.angle_start);
    end else begin
      front_c = front_q;
      left_c  = left_q;
      right_c = right_q;
      a = angle_q;
    end

    in_range = (r >= cfg_i.dist_floor) && (r <= cfg_i.dist_ceil);
    in_left  = (a < -ssc_pkg::HALF_RAD) && (a >= -ssc_pkg::EDGE_RAD);
    in_right = (a > ssc_pkg::HALF_RAD) && (a <= ssc_pkg::EDGE_RAD);
    in_front = (a >= -ssc_pkg::HALF_RAD) && (a <= ssc_pkg::HALF_RAD);

    front_d = front_c;
    left_d  = left_c;
    right_d = right_c;
    if (in_range && in_left && (r < left_c)) left_d = r;
    if (in_range && in_right && (r < right_c)) right_d = r;
    if (in_range && in_front && (r < front_c)) front_d = r;

    sum = (AW+1)'(a) + (AW+1)'(cfg_i.angle_step);
    if (sum[AW] != sum[AW-1]) begin
      angle_d = sum[AW] ? ssc_pkg::ANGLE_SAT_LO : ssc_pkg::ANGLE_SAT_HI;
    end else begin
      angle_d = sum[AW-1:0];
    end

    start_d = item_i.last_sample;

    left_x5   = {1'b0, left_d, 2'b00} + (RW+3)'(left_d);
    right_x5  = {1'b0, right_d, 2'b00} + (RW+3)'(right_d);
    safety_x3 = {2'b00, cfg_i.safety_distance, 1'b0} + (RW+3)'(cfg_i.safety_distance);

    res_o.front_clearance = front_d;
    res_o.left_clearance  = left_d;
    res_o.right_clearance = right_d;
    res_o.obstacle_flag   = (front_d < cfg_i.safety_distance) ||
                            (left_x5 < safety_x3) || (right_x5 < safety_x3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      left_q  <= '0;
      right_q <= '0;
      angle_q <= '0;
      start_q <= 1'b1;
    end else if (proc_i) begin
      front_q <= front_d;
      left_q  <= left_d;
      right_q <= right_d;
      angle_q <= angle_d;
      start_q <= start_d;
    end
  end

  a_start_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && item_i.last_sample |=> start_q)
    else $error("scan start not armed after last item");

  a_no_start_mid_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && !item_i.last_sample |=> !start_q)
    else $error("scan start armed in mid scan");

endmodule
`default_nettype wire

>>> rtl/scan_sector_clearance.sv
// Laser scan sector clearance: takes one range sample per item and keeps the
// minimum valid range in the left, front and right sectors while stepping the
// beam angle from angle_start by angle_step. The item marked last emits one
// result with the three minima and the obstacle flag. Throughput is one item
// per clock unless the input stalls; each item passes an input register, then
// the compare, min and angle accumulate logic, and the result register loads
// when its last item is processed.
// Input stalls only while a finished result waits in the output register and
// the next last item would need that slot.
`default_nettype none
module scan_sector_clearance (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ssc_pkg::RangeW-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output      logic                         in_stall_o,
  input  wire ssc_pkg::in_item_t            in_item_i,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i,
  output ssc_pkg::out_item_t                out_item_o
);

  ssc_pkg::cfg_t      cfg;
  ssc_pkg::in_item_t  in_d, in_q;
  ssc_pkg::out_item_t res, out_d, out_q;
  logic in_vld_d, in_vld_q, out_vld_d, out_vld_q;
  logic proc, in_acc;

  ssc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssc_sector_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .proc_i (proc),
    .item_i (in_q),
    .res_o  (res)
  );

  // a non-last item never needs the output slot
  assign proc = in_vld_q && (!in_q.last_sample || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proc;
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    in_d = in_q;
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_d = in_item_i;
      in_vld_d = 1'b1;
    end else if (proc) begin
      in_vld_d = 1'b0;
    end

    out_d = out_q;
    out_vld_d = out_vld_q;
    if (proc && in_q.last_sample) begin
      out_d = res;
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_stall_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && in_q.last_sample && out_vld_q && out_stall_i)
    else $error("input stalled without a blocked result");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(proc && in_q.last_sample))
    else $error("result offered without a last item");

  a_result_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("stalled result dropped or overwritten");

endmodule
`default_nettype wire

>>> tb/scan_clearance_checker.sv
`timescale 1ns / 1ps
module scan_clearance_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [ssc_pkg::RangeW-1:0]    cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire ssc_pkg::in_item_t             in_item_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire ssc_pkg::out_item_t            out_item_i,
  output int                                 pending_o,
  output int                                 errors_o,
  output int                                 results_o
);

  localparam int unsigned RW = ssc_pkg::RangeW;
  localparam int unsigned AW = ssc_pkg::AngleW;

  localparam ssc_pkg::cfg_t RESET_REGS = '{
    dist_floor:      16'd100,
    dist_ceil:       16'd12000,
    angle_start:     -16'sd25736,
    angle_step:      14'sd143,
    safety_distance: 16'd500
  };

  ssc_pkg::cfg_t        regs;
  logic [RW-1:0]        front_min;
  logic [RW-1:0]        left_min;
  logic [RW-1:0]        right_min;
  logic signed [AW-1:0] angle_now;
  logic                 scan_starting;
  ssc_pkg::out_item_t   clearance_q [$];
  int                   pending;
  int                   errors;
  int                   results;

  assign pending_o = pending;
  assign errors_o  = errors;
  assign results_o = results;

  // one accepted item: update the sector minima, step the beam angle,
  // and queue the clearance report when the scan closes
  function automatic void take_sample(ssc_pkg::in_item_t it);
    logic [RW-1:0]        r;
    logic signed [AW-1:0] a;
    longint               next;
    longint               s3;
    ssc_pkg::out_item_t   rep;
    r = it.range_sample;
    if (scan_starting) begin
      front_min     = regs.dist_ceil;
      left_min      = regs.dist_ceil;
      right_min     = regs.dist_ceil;
      angle_now     = AW'(regs.angle_start);
      scan_starting = 1'b0;
    end
    a = angle_now;
    if (r >= regs.dist_floor && r <= regs.dist_ceil) begin
      if (a < -ssc_pkg::HALF_RAD && a >= -ssc_pkg::EDGE_RAD) begin
        if (r < left_min) left_min = r;
      end else if (a > ssc_pkg::HALF_RAD && a <= ssc_pkg::EDGE_RAD) begin
        if (r < right_min) right_min = r;
      end else if (a >= -ssc_pkg::HALF_RAD && a <= ssc_pkg::HALF_RAD) begin
        if (r < front_min) front_min = r;
      end
    end
    // angle saturates instead of wrapping
    next = longint'(angle_now) + longint'($signed(regs.angle_step));
    if (next > longint'(ssc_pkg::ANGLE_SAT_HI)) next = longint'(ssc_pkg::ANGLE_SAT_HI);
    if (next < longint'(ssc_pkg::ANGLE_SAT_LO)) next = longint'(ssc_pkg::ANGLE_SAT_LO);
    angle_now = next[AW-1:0];
    if (it.last_sample) begin
      s3 = 3 * longint'(regs.safety_distance);
      rep.front_clearance = front_min;
      rep.left_clearance  = left_min;
      rep.right_clearance = right_min;
      rep.obstacle_flag   = (front_min < regs.safety_distance) ||
                            (5 * longint'(left_min) < s3) ||
                            (5 * longint'(right_min) < s3);
      clearance_q.push_back(rep);
      scan_starting = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ssc_pkg::out_item_t want;
    if (!rst_ni) begin
      regs          = RESET_REGS;
      front_min     = '0;
      left_min      = '0;
      right_min     = '0;
      angle_now     = '0;
      scan_starting = 1'b1;
      clearance_q.delete();
      pending       = 0;
      errors        = 0;
      results       = 0;
    end else begin
      if (cfg_we_i) begin
        case (ssc_pkg::cfg_idx_e'(cfg_idx_i))
          ssc_pkg::CFG_DIST_FLOOR:  regs.dist_floor      = cfg_wdata_i;
          ssc_pkg::CFG_DIST_CEIL:   regs.dist_ceil       = cfg_wdata_i;
          ssc_pkg::CFG_ANGLE_START: regs.angle_start     = cfg_wdata_i;
          ssc_pkg::CFG_ANGLE_STEP:  regs.angle_step      = cfg_wdata_i[ssc_pkg::StepW-1:0];
          ssc_pkg::CFG_SAFETY:      regs.safety_distance = cfg_wdata_i;
          default: ;
        endcase
      end
      // results first: an item taken at this edge cannot be reported yet
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (clearance_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result front %0d left %0d right %0d flag %0b",
                     $realtime, out_item_i.front_clearance, out_item_i.left_clearance,
                     out_item_i.right_clearance, out_item_i.obstacle_flag);
        end else begin
          want = clearance_q.pop_front();
          if (out_item_i.front_clearance !== want.front_clearance ||
              out_item_i.left_clearance !== want.left_clearance ||
              out_item_i.right_clearance !== want.right_clearance ||
              out_item_i.obstacle_flag !== want.obstacle_flag) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       $realtime, want.front_clearance, want.left_clearance,
                       want.right_clearance, want.obstacle_flag,
                       out_item_i.front_clearance, out_item_i.left_clearance,
                       out_item_i.right_clearance, out_item_i.obstacle_flag);
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_sample(in_item_i);
      pending = clearance_q.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

  localparam int RW          = ssc_pkg::RangeW;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE      = 4;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 84;
  localparam int SECTOR_EDGES [10] = '{-12862, -12861, -4097, -4096, -4095,
                                        4095, 4096, 4097, 12861, 12862};

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  ssc_pkg::cfg_idx_e  cfg_idx   = ssc_pkg::CFG_DIST_FLOOR;
  logic [RW-1:0]      cfg_wdata = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  ssc_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ssc_pkg::out_item_t out_item;

  int   pending;
  int   errors;
  int   results;
  int   idle_pct  = 0;
  int   stall_pct = 0;
  int   samples_sent = 0;
  int   settings_loaded = 0;
  int   cycles = 0;
  ssc_pkg::cfg_t cur;

  scan_sector_clearance DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  scan_clearance_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_item_i   (in_item),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_item_i  (out_item),
    .pending_o   (pending),
    .errors_o    (errors),
    .results_o   (results)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic ssc_pkg::cfg_t mk(int rmin, int rmax, int start, int step, int safety);
    ssc_pkg::cfg_t c;
    c.dist_floor      = rmin[RW-1:0];
    c.dist_ceil       = rmax[RW-1:0];
    c.angle_start     = start[ssc_pkg::StartW-1:0];
    c.angle_step      = step[ssc_pkg::StepW-1:0];
    c.safety_distance = safety[RW-1:0];
    return c;
  endfunction

  function automatic ssc_pkg::cfg_t phase_cfg(int ph);
    int rmin, rmax, start, step, safety, sel;
    case (ph)
      0: return mk(0, 65535, -32768, 4096, 65535);
      1: return mk(0, 0, 32767, -4096, 0);
      2: return mk(65535, 65535, 0, 0, 65535);
      default: ;
    endcase
    rmin = ($urandom_range(9) == 0) ? 0 : $urandom_range(2000);
    sel  = $urandom_range(9);
    if (sel == 0)      rmax = 65535;
    else if (sel == 1) rmax = $urandom_range(rmin);
    else               rmax = rmin + $urandom_range(20000);
    if ($urandom_range(9) < 3) start = SECTOR_EDGES[$urandom_range(9)];
    else                       start = int'($urandom_range(32768)) - 16384;
    case ($urandom_range(19))
      0:       step = 1;
      1:       step = -1;
      2:       step = 0;
      3:       step = 4096;
      4:       step = -4096;
      default: step = int'($urandom_range(1600)) - 800;
    endcase
    sel = $urandom_range(9);
    if (sel == 0)      safety = 0;
    else if (sel == 1) safety = 65535;
    else               safety = $urandom_range(15000, 200);
    return mk(rmin, rmax, start, step, safety);
  endfunction

  // ranges cluster on the window bounds and on both obstacle thresholds
  function automatic logic [RW-1:0] pick_range();
    int sel, v, lo, hi;
    sel = $urandom_range(99);
    lo  = cur.dist_floor;
    hi  = cur.dist_ceil;
    if (sel < 8)       v = $urandom_range(1) ? 65535 : 0;
    else if (sel < 18) v = $urandom_range(65535);
    else if (sel < 24) v = $urandom_range(1) ? lo : hi;
    else if (sel < 34) v = int'(cur.safety_distance) * 3 / 5 + int'($urandom_range(2)) - 1;
    else if (sel < 40) v = int'(cur.safety_distance) + int'($urandom_range(2)) - 1;
    else if (lo <= hi) v = $urandom_range(hi, lo);
    else               v = $urandom_range(65535);
    return v[RW-1:0];
  endfunction

  function automatic int scan_len();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return $urandom_range(20, 1);
    if (sel < 95) return $urandom_range(80, 21);
    return $urandom_range(300, 81);
  endfunction

  task automatic load_regs(ssc_pkg::cfg_t c);
    ssc_pkg::cfg_idx_e order [5];
    logic [RW-1:0]     vals [5];
    order = '{ssc_pkg::CFG_DIST_FLOOR, ssc_pkg::CFG_DIST_CEIL, ssc_pkg::CFG_ANGLE_START,
              ssc_pkg::CFG_ANGLE_STEP, ssc_pkg::CFG_SAFETY};
    vals  = '{c.dist_floor, c.dist_ceil, c.angle_start,
              {{(RW-ssc_pkg::StepW){c.angle_step[ssc_pkg::StepW-1]}}, c.angle_step},
              c.safety_distance};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = c;
    settings_loaded++;
  endtask

  task automatic send(logic [RW-1:0] r, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_item  <= ssc_pkg::in_item_t'($urandom);
      @(posedge clk);
    end
    in_valid             <= 1'b1;
    in_item.range_sample <= r;
    in_item.last_sample  <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  // hold off until every report is back, then let the pipe drain
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_scan(int n, logic close);
    for (int i = 0; i < n; i++) send(pick_range(), close && (i == n - 1));
  endtask

  initial begin
    int  count;
    int  n;
    bit  paused;
    cur = mk(100, 12000, -25736, 143, 500);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample scans on the reset settings
    send(16'd0, 1'b1);
    send(16'd65535, 1'b1);

    // beams stepped across all three sectors and beyond the field of view
    quiesce();
    load_regs(mk(0, 65535, -16384, 4096, 65535));
    send(16'd0, 1'b0);
    send(16'd65535, 1'b0);
    send(16'd300, 1'b0);
    send(16'd0, 1'b0);
    send(16'd65535, 1'b0);
    send(16'd1000, 1'b0);
    send(16'd40000, 1'b0);
    send(16'd65535, 1'b0);
    send(16'd1, 1'b1);

    // floor above ceiling: nothing valid, every sector reports the ceiling
    quiesce();
    load_regs(mk(5000, 4000, -4096, 1000, 3000));
    send(16'd4500, 1'b0);
    send(16'd5000, 1'b0);
    send(16'd4000, 1'b0);
    send(16'd100, 1'b1);

    // sector edges and the 0.6 side threshold, just held and just missed
    quiesce();
    load_regs(mk(0, 65535, -4097, 1, 1000));
    send(16'd600, 1'b0);
    send(16'd1000, 1'b1);
    quiesce();
    load_regs(mk(0, 65535, 4096, 1, 1000));
    send(16'd1000, 1'b0);
    send(16'd599, 1'b1);

    // settings change in the middle of a scan
    quiesce();
    load_regs(mk(0, 20000, -8192, 2048, 800));
    send(16'd300, 1'b0);
    send(16'd2000, 1'b0);
    quiesce();
    load_regs(mk(400, 20000, 0, 1024, 800));
    send(16'd350, 1'b0);
    send(16'd900, 1'b0);
    send(16'd25000, 1'b1);

    paused = 1'b0;
    for (int ph = 0; ph < PHASES; ph++) begin
      quiesce();
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 59; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 59; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      load_regs(phase_cfg(ph));
      count = 0;
      while (count < PHASE_ITEMS) begin
        n = scan_len();
        run_scan(n, 1'b1);
        count += n;
        if (ph == 5 && !paused && count >= PHASE_ITEMS / 2) begin
          quiesce();
          paused = 1'b1;
        end
      end
      // sometimes leave a scan open across the next settings change
      if (ph < PHASES - 1 && $urandom_range(3) == 0) run_scan($urandom_range(12, 1), 1'b0);
    end

    quiesce();
    repeat (SETTLE) @(posedge clk);
    $display("summary: %0d samples in, %0d scan reports checked, %0d register settings",
             samples_sent, results, settings_loaded);
    $display("summary: sector edges, empty windows, mid-scan changes, idle and stall mixes");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ssc_pkg.sv
rtl/ssc_cfg_regs.sv
rtl/ssc_sector_track.sv
rtl/scan_sector_clearance.sv
tb/scan_clearance_checker.sv
tb/tb_top.sv
